### hw/rtl/irp_pkg.sv
// Shared types and constants for the initiate request parser.
`default_nettype none

package irp_pkg;

    localparam int unsigned KEY_MAX = 32;

    localparam logic [7:0] CONF_TAG0 = 8'h5F;
    localparam logic [7:0] CONF_TAG1 = 8'h1F;
    localparam logic [7:0] FLAG_ABSENT = 8'h00;
    localparam logic [7:0] FLAG_PRESENT = 8'h01;

    localparam int unsigned TDATA_W = 88;

    typedef enum logic [4:0] {
        PH_TAG, PH_KEYFLAG, PH_KEYLEN, PH_KEY, PH_RAFLAG, PH_RAVAL, PH_QFLAG,
        PH_QVAL, PH_VER, PH_CT1, PH_CT2, PH_CT2_BAD, PH_CLEN, PH_CLEN_BAD,
        PH_CUNUSED, PH_CBYTES, PH_PDUH, PH_PDUL, PH_DRAIN
    } phase_t;

    typedef enum logic [1:0] {
        KIND_KEY_BYTE = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_ERROR    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TAG       = 3'd1,
        ERR_FLAG      = 3'd2,
        ERR_KEY_LONG  = 3'd3,
        ERR_TRUNCATED = 3'd4,
        ERR_CONF_TAG  = 3'd5,
        ERR_CONF_LEN  = 3'd6
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } byte_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         key_byte;
        logic [5:0]         key_length;
        logic               has_key;
        logic               reply_allowed;
        logic               has_qos;
        logic signed [7:0]  qos_value;
        logic [7:0]         dlms_version;
        logic [31:0]        conformance;
        logic [15:0]        max_pdu_size;
        err_t               error_code;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/irp_in_reg.sv
// Input register stage that holds one accepted byte for the decoder.
`default_nettype none

module irp_in_reg (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire irp_pkg::byte_item_t s_item,
    input  wire logic                consume,
    output logic                     item_valid,
    output irp_pkg::byte_item_t      item
);
    import irp_pkg::*;

    logic       valid_reg;
    byte_item_t item_reg;

    assign s_ready    = !valid_reg || consume;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/irp_decode.sv
// Decoder state and the per-byte next-state and result logic.
`default_nettype none

module irp_decode (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [7:0]          cfg_wdata,
    input  wire logic                consume,
    input  wire irp_pkg::byte_item_t item,
    output logic                     res_valid,
    output irp_pkg::result_t         res
);
    import irp_pkg::*;

    logic [7:0]  request_tag_reg;
    phase_t      phase_reg,  phase_next;
    logic [7:0]  left_reg,   left_next;
    logic [31:0] conf_reg,   conf_next;
    logic [7:0]  pdu_hi_reg, pdu_hi_next;
    logic [5:0]  klen_reg,   klen_next;
    logic        has_key_reg, has_key_next;
    logic        resp_reg,   resp_next;
    logic        has_qos_reg, has_qos_next;
    logic [7:0]  qos_reg,    qos_next;
    logic [7:0]  ver_reg,    ver_next;

    logic [7:0] b;
    logic       last;
    logic       cont;
    logic       err_hit;
    err_t       err_code;
    logic [7:0] left_dec;

    assign b        = item.data_byte;
    assign last     = item.buffer_end;
    assign left_dec = left_reg - 8'd1;

    always_comb begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        conf_next    = conf_reg;
        pdu_hi_next  = pdu_hi_reg;
        klen_next    = klen_reg;
        has_key_next = has_key_reg;
        resp_next    = resp_reg;
        has_qos_next = has_qos_reg;
        qos_next     = qos_reg;
        ver_next     = ver_reg;
        cont         = 1'b0;
        err_hit      = 1'b0;
        err_code     = ERR_NONE;
        res_valid    = 1'b0;
        res          = '0;
        res.kind       = KIND_KEY_BYTE;
        res.error_code = ERR_NONE;

        case (phase_reg)
            PH_TAG: begin
                if (b != request_tag_reg) begin
                    err_hit  = 1'b1;
                    err_code = ERR_TAG;
                end else begin
                    klen_next    = '0;
                    has_key_next = 1'b0;
                    resp_next    = 1'b1;
                    has_qos_next = 1'b0;
                    qos_next     = '0;
                    ver_next     = '0;
                    conf_next    = '0;
                    pdu_hi_next  = '0;
                    left_next    = '0;
                    phase_next   = PH_KEYFLAG;
                    cont         = 1'b1;
                end
            end
            PH_KEYFLAG: begin
                cont = 1'b1;
                if (b == FLAG_ABSENT) begin
                    phase_next = PH_RAFLAG;
                end else if (b == FLAG_PRESENT) begin
                    phase_next = PH_KEYLEN;
                end else begin
                    cont     = 1'b0;
                    err_hit  = 1'b1;
                    err_code = ERR_FLAG;
                end
            end
            PH_KEYLEN: begin
                if (b > 8'(KEY_MAX)) begin
                    err_hit  = 1'b1;
                    err_code = ERR_KEY_LONG;
                end else begin
                    has_key_next = 1'b1;
                    klen_next    = '0;
                    left_next    = b;
                    phase_next   = (b != 8'd0) ? PH_KEY : PH_RAFLAG;
                    cont         = 1'b1;
                end
            end
            PH_KEY: begin
                if (last) begin
                    err_hit  = 1'b1;
                    err_code = ERR_TRUNCATED;
                end else begin
                    klen_next      = klen_reg + 6'd1;
                    left_next      = left_dec;
                    res_valid      = 1'b1;
                    res.kind       = KIND_KEY_BYTE;
                    res.key_byte   = b;
                    res.key_length = klen_reg + 6'd1;
                    res.has_key    = 1'b1;
                    if (left_dec == 8'd0) begin
                        phase_next = PH_RAFLAG;
                    end
                end
            end
            PH_RAFLAG: begin
                cont = 1'b1;
                if (b == FLAG_ABSENT) begin
                    resp_next  = 1'b1;
                    phase_next = PH_QFLAG;
                end else if (b == FLAG_PRESENT) begin
                    phase_next = PH_RAVAL;
                end else begin
                    cont     = 1'b0;
                    err_hit  = 1'b1;
                    err_code = ERR_FLAG;
                end
            end
            PH_RAVAL: begin
                resp_next  = (b != 8'd0);
                phase_next = PH_QFLAG;
                cont       = 1'b1;
            end
            PH_QFLAG: begin
                cont = 1'b1;
                if (b == FLAG_ABSENT) begin
                    has_qos_next = 1'b0;
                    phase_next   = PH_VER;
                end else if (b == FLAG_PRESENT) begin
                    phase_next = PH_QVAL;
                end else begin
                    cont     = 1'b0;
                    err_hit  = 1'b1;
                    err_code = ERR_FLAG;
                end
            end
            PH_QVAL: begin
                qos_next     = b;
                has_qos_next = 1'b1;
                phase_next   = PH_VER;
                cont         = 1'b1;
            end
            PH_VER: begin
                ver_next   = b;
                phase_next = PH_CT1;
                cont       = 1'b1;
            end
            PH_CT1: begin
                phase_next = (b == CONF_TAG0) ? PH_CT2 : PH_CT2_BAD;
                cont       = 1'b1;
            end
            PH_CT2: begin
                phase_next = (b == CONF_TAG1) ? PH_CLEN : PH_CLEN_BAD;
                cont       = 1'b1;
            end
            PH_CT2_BAD: begin
                phase_next = PH_CLEN_BAD;
                cont       = 1'b1;
            end
            PH_CLEN_BAD: begin
                err_hit  = 1'b1;
                err_code = ERR_CONF_TAG;
            end
            PH_CLEN: begin
                if (b == 8'd0) begin
                    err_hit  = 1'b1;
                    err_code = ERR_CONF_LEN;
                end else begin
                    left_next  = b - 8'd1;
                    conf_next  = '0;
                    phase_next = PH_CUNUSED;
                    cont       = 1'b1;
                end
            end
            PH_CUNUSED: begin
                phase_next = (left_reg != 8'd0) ? PH_CBYTES : PH_PDUH;
                cont       = 1'b1;
            end
            PH_CBYTES: begin
                conf_next = {conf_reg[23:0], b};
                left_next = left_dec;
                if (left_dec == 8'd0) begin
                    phase_next = PH_PDUH;
                end
                cont = 1'b1;
            end
            PH_PDUH: begin
                pdu_hi_next = b;
                phase_next  = PH_PDUL;
                cont        = 1'b1;
            end
            PH_PDUL: begin
                res_valid         = 1'b1;
                res.kind          = KIND_DONE;
                res.key_length    = klen_reg;
                res.has_key       = has_key_reg;
                res.reply_allowed = resp_reg;
                res.has_qos       = has_qos_reg;
                res.qos_value     = qos_reg;
                res.dlms_version  = ver_reg;
                res.conformance   = conf_reg;
                res.max_pdu_size  = {pdu_hi_reg, b};
                phase_next        = last ? PH_TAG : PH_DRAIN;
            end
            default: begin
                if (last) begin
                    phase_next = PH_TAG;
                end
            end
        endcase

        if (cont && last) begin
            err_hit  = 1'b1;
            err_code = ERR_TRUNCATED;
        end

        if (err_hit) begin
            res_valid      = 1'b1;
            res            = '0;
            res.kind       = KIND_ERROR;
            res.error_code = err_code;
            phase_next     = last ? PH_TAG : PH_DRAIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            request_tag_reg <= 8'd1;
            phase_reg       <= PH_TAG;
            left_reg        <= '0;
            conf_reg        <= '0;
            pdu_hi_reg      <= '0;
            klen_reg        <= '0;
            has_key_reg     <= 1'b0;
            resp_reg        <= 1'b1;
            has_qos_reg     <= 1'b0;
            qos_reg         <= '0;
            ver_reg         <= '0;
        end else begin
            if (cfg_we) begin
                request_tag_reg <= cfg_wdata;
            end
            if (consume) begin
                phase_reg   <= phase_next;
                left_reg    <= left_next;
                conf_reg    <= conf_next;
                pdu_hi_reg  <= pdu_hi_next;
                klen_reg    <= klen_next;
                has_key_reg <= has_key_next;
                resp_reg    <= resp_next;
                has_qos_reg <= has_qos_next;
                qos_reg     <= qos_next;
                ver_reg     <= ver_next;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/irp_out_reg.sv
// Result register with a skid entry so the decoder can push one more result under a stall.
`default_nettype none

module irp_out_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire irp_pkg::result_t push_res,
    output logic                  can_push,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output irp_pkg::result_t      m_res
);
    import irp_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    advance;

    assign can_push = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_res    = main_reg;
    assign advance  = !main_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (advance) begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            main_reg <= skid_valid_reg ? skid_reg : push_res;
        end else if (push) begin
            skid_reg <= push_res;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/initiate_request_parser.sv
// Top level of the byte-serial initiate request parser.
`default_nettype none

// The parser takes one request byte per transfer, with tlast on the last byte of
// the buffer, and returns key byte echoes and one final transfer that carries the
// decoded fields or an error code. It accepts a byte in every cycle unless the output
// buffer is full; a byte's result passes through the input register and then the
// result register, where a two-entry output buffer absorbs stalls. The user must write
// the expected request tag through cfg_we and cfg_wdata while idle (not enforced).
module initiate_request_parser (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [7:0]   cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
    input  wire logic         s_tlast,   // buffer_end
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [7:0] key_byte, [13:8] key_length, [14] has_key, [15] reply_allowed,
    // [16] has_qos, [24:17] qos_value, [32:25] dlms_version,
    // [64:33] conformance, [80:65] max_pdu_size, [83:81] error_code, rest zero
    output logic [irp_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]        m_tuser    // [1:0] kind
);
    import irp_pkg::*;

    byte_item_t s_item;
    byte_item_t item;
    logic       item_valid;
    logic       consume;
    logic       can_push;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    assign s_item.data_byte  = s_tdata;
    assign s_item.buffer_end = s_tlast;
    assign consume = item_valid && can_push;

    irp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    irp_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .consume   (consume),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    irp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (consume && res_valid),
        .push_res (res),
        .can_push (can_push),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    assign m_tuser = m_res.kind;
    assign m_tdata = {4'd0, m_res.error_code, m_res.max_pdu_size, m_res.conformance,
                      m_res.dlms_version, m_res.qos_value, m_res.has_qos,
                      m_res.reply_allowed, m_res.has_key, m_res.key_length,
                      m_res.key_byte};

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the initiate request parser: directed table, then random requests.
`timescale 1ns / 100ps

module tb_top;
    import irp_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         typed;
        err_t       code;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [7:0]          cfg_wdata = 8'h00;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = 8'h00;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [1:0]          m_tuser;

    // Decoder state mirrored by the predictor.
    phase_t      ph = PH_TAG;
    logic [7:0]  tag_reg = 8'h01;
    logic [7:0]  remain = 8'h00;
    logic [31:0] conf_acc = 32'h0;
    logic [7:0]  pdu_hi = 8'h00;
    logic [5:0]  key_cnt = 6'd0;
    logic        has_key_s = 1'b0;
    logic        resp_s = 1'b1;
    logic        qos_s = 1'b0;
    logic [7:0]  qos_v = 8'h00;
    logic [7:0]  ver_v = 8'h00;

    result_t     exp_q[$];
    int          errors = 0;
    int          results_seen = 0;
    int          sent = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;
    bit          long_hold_done = 1'b0;

    initiate_request_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic result_t fail_request(err_t code, logic last);
        result_t r;
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = code;
        ph = last ? PH_TAG : PH_DRAIN;
        return r;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic last, output result_t r);
        r = '0;
        case (ph)
            PH_TAG: begin
                if (b != tag_reg) begin
                    r = fail_request(ERR_TAG, last);
                    return 1'b1;
                end
                key_cnt = 6'd0;
                has_key_s = 1'b0;
                resp_s = 1'b1;
                qos_s = 1'b0;
                qos_v = 8'h00;
                ver_v = 8'h00;
                conf_acc = 32'h0;
                pdu_hi = 8'h00;
                remain = 8'h00;
                ph = PH_KEYFLAG;
            end
            PH_KEYFLAG: begin
                if (b == FLAG_ABSENT) ph = PH_RAFLAG;
                else if (b == FLAG_PRESENT) ph = PH_KEYLEN;
                else begin
                    r = fail_request(ERR_FLAG, last);
                    return 1'b1;
                end
            end
            PH_KEYLEN: begin
                if (b > KEY_MAX) begin
                    r = fail_request(ERR_KEY_LONG, last);
                    return 1'b1;
                end
                has_key_s = 1'b1;
                key_cnt = 6'd0;
                remain = b;
                ph = (b != 8'h00) ? PH_KEY : PH_RAFLAG;
            end
            PH_KEY: begin
                if (last) begin
                    r = fail_request(ERR_TRUNCATED, last);
                    return 1'b1;
                end
                key_cnt = key_cnt + 6'd1;
                r.kind = KIND_KEY_BYTE;
                r.key_byte = b;
                r.key_length = key_cnt;
                r.has_key = 1'b1;
                remain = remain - 8'd1;
                if (remain == 8'h00) ph = PH_RAFLAG;
                return 1'b1;
            end
            PH_RAFLAG: begin
                if (b == FLAG_ABSENT) begin
                    resp_s = 1'b1;
                    ph = PH_QFLAG;
                end else if (b == FLAG_PRESENT) begin
                    ph = PH_RAVAL;
                end else begin
                    r = fail_request(ERR_FLAG, last);
                    return 1'b1;
                end
            end
            PH_RAVAL: begin
                resp_s = (b != 8'h00);
                ph = PH_QFLAG;
            end
            PH_QFLAG: begin
                if (b == FLAG_ABSENT) begin
                    qos_s = 1'b0;
                    ph = PH_VER;
                end else if (b == FLAG_PRESENT) begin
                    ph = PH_QVAL;
                end else begin
                    r = fail_request(ERR_FLAG, last);
                    return 1'b1;
                end
            end
            PH_QVAL: begin
                qos_v = b;
                qos_s = 1'b1;
                ph = PH_VER;
            end
            PH_VER: begin
                ver_v = b;
                ph = PH_CT1;
            end
            PH_CT1: ph = (b == CONF_TAG0) ? PH_CT2 : PH_CT2_BAD;
            PH_CT2: ph = (b == CONF_TAG1) ? PH_CLEN : PH_CLEN_BAD;
            PH_CT2_BAD: ph = PH_CLEN_BAD;
            PH_CLEN_BAD: begin
                r = fail_request(ERR_CONF_TAG, last);
                return 1'b1;
            end
            PH_CLEN: begin
                if (b == 8'h00) begin
                    r = fail_request(ERR_CONF_LEN, last);
                    return 1'b1;
                end
                remain = b - 8'd1;
                conf_acc = 32'h0;
                ph = PH_CUNUSED;
            end
            PH_CUNUSED: ph = (remain != 8'h00) ? PH_CBYTES : PH_PDUH;
            PH_CBYTES: begin
                conf_acc = {conf_acc[23:0], b};
                remain = remain - 8'd1;
                if (remain == 8'h00) ph = PH_PDUH;
            end
            PH_PDUH: begin
                pdu_hi = b;
                ph = PH_PDUL;
            end
            PH_PDUL: begin
                r.kind = KIND_DONE;
                r.key_length = key_cnt;
                r.has_key = has_key_s;
                r.reply_allowed = resp_s;
                r.has_qos = qos_s;
                r.qos_value = qos_v;
                r.dlms_version = ver_v;
                r.conformance = conf_acc;
                r.max_pdu_size = {pdu_hi, b};
                ph = last ? PH_TAG : PH_DRAIN;
                return 1'b1;
            end
            default: begin
                if (last) ph = PH_TAG;
                return 1'b0;
            end
        endcase
        if (last) begin
            r = fail_request(ERR_TRUNCATED, last);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input err_t code);
        int      gap;
        bit      got;
        result_t r;
        if (sent % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
        sent++;
        gap = send_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        got = parse_byte(b, last, r);
        if (typed) begin
            r = '0;
            r.kind = KIND_ERROR;
            r.error_code = code;
            exp_q.push_back(r);
        end else if (got) begin
            exp_q.push_back(r);
        end
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (exp_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_request_tag(input logic [7:0] v);
        pause_until_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tag_reg = v;
    endtask

    // Mostly well-formed requests with random content; some are cut short or corrupted,
    // a few are plain noise. Bytes trailing a request are not counted.
    task automatic queue_request(output int counted);
        logic [7:0] req[$];
        int         style, klen, clen, trail, pos, n;
        style = $urandom_range(0, 9);
        trail = 0;
        if (style == 9) begin
            n = $urandom_range(1, 4);
            repeat (n) req.push_back(8'($urandom_range(0, 255)));
        end else begin
            req.push_back(tag_reg);
            if ($urandom_range(0, 1) == 1) begin
                req.push_back(FLAG_PRESENT);
                klen = ($urandom_range(0, 7) == 0) ? KEY_MAX : $urandom_range(0, 6);
                req.push_back(8'(klen));
                repeat (klen) req.push_back(8'($urandom_range(0, 255)));
            end else begin
                req.push_back(FLAG_ABSENT);
            end
            case ($urandom_range(0, 2))
                0: req.push_back(FLAG_ABSENT);
                1: begin
                    req.push_back(FLAG_PRESENT);
                    req.push_back(8'h00);
                end
                default: begin
                    req.push_back(FLAG_PRESENT);
                    req.push_back(8'($urandom_range(1, 255)));
                end
            endcase
            if ($urandom_range(0, 1) == 1) begin
                req.push_back(FLAG_PRESENT);
                req.push_back(8'($urandom_range(0, 255)));
            end else begin
                req.push_back(FLAG_ABSENT);
            end
            req.push_back(8'($urandom_range(0, 255)));
            req.push_back(CONF_TAG0);
            req.push_back(CONF_TAG1);
            clen = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
            req.push_back(8'(clen));
            repeat (clen) req.push_back(8'($urandom_range(0, 255)));
            req.push_back(8'($urandom_range(0, 255)));
            req.push_back(8'($urandom_range(0, 255)));
            if (style >= 7) begin
                pos = $urandom_range(0, req.size() - 1);
                if ($urandom_range(0, 1) == 1) req = req[0:pos];
                else req[pos] = 8'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 3) == 0) trail = $urandom_range(1, 3);
        end
        counted = req.size();
        repeat (trail) req.push_back(8'($urandom_range(0, 255)));
        foreach (req[i]) send_byte(req[i], i == req.size() - 1, 1'b0, ERR_NONE);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    initial begin
        dir_row_t   dir_tab[27];
        logic [7:0] tags[4];
        int         counted, n;
        dir_tab = '{
            '{8'h00, 1'b1, 1'b1, ERR_TAG},
            '{8'h01, 1'b0, 1'b0, ERR_NONE}, '{8'h07, 1'b1, 1'b1, ERR_FLAG},
            '{8'h01, 1'b0, 1'b0, ERR_NONE}, '{8'h01, 1'b0, 1'b0, ERR_NONE},
            '{8'h21, 1'b1, 1'b1, ERR_KEY_LONG},
            '{8'h01, 1'b0, 1'b0, ERR_NONE}, '{8'h01, 1'b0, 1'b0, ERR_NONE},
            '{8'h01, 1'b0, 1'b0, ERR_NONE}, '{8'hFF, 1'b1, 1'b1, ERR_TRUNCATED},
            '{8'h01, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b0, 1'b0, ERR_NONE},
            '{8'h00, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b0, 1'b0, ERR_NONE},
            '{8'h06, 1'b0, 1'b0, ERR_NONE}, '{8'h5E, 1'b0, 1'b0, ERR_NONE},
            '{8'h1F, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b0, 1'b1, ERR_CONF_TAG},
            '{8'hFF, 1'b1, 1'b0, ERR_NONE},
            '{8'h01, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b0, 1'b0, ERR_NONE},
            '{8'h00, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b0, 1'b0, ERR_NONE},
            '{8'hFF, 1'b0, 1'b0, ERR_NONE}, '{8'h5F, 1'b0, 1'b0, ERR_NONE},
            '{8'h1F, 1'b0, 1'b0, ERR_NONE}, '{8'h00, 1'b1, 1'b1, ERR_CONF_LEN}
        };
        tags[0] = 8'h00;
        tags[1] = 8'hFF;
        tags[2] = 8'($urandom_range(2, 254));
        tags[3] = 8'h01;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (dir_tab[i])
            send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].code);
        foreach (tags[p]) begin
            set_request_tag(tags[p]);
            counted = 0;
            while (counted < 225) begin
                queue_request(n);
                counted += n;
            end
        end
        pause_until_drained();
        if (errors == 0) $display("initiate_request_parser: match");
        else $display("initiate_request_parser: mismatch");
        $finish;
    end

    initial begin
        int      stall;
        result_t e;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results_seen % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
            stall = recv_calm ? 0 : $urandom_range(0, 15);
            if (!long_hold_done && results_seen >= 40) begin
                // Long hold-off so the output buffer fills and the input stalls.
                long_hold_done = 1'b1;
                stall = 300;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            results_seen++;
            if (exp_q.size() == 0) begin
                $error("result with no expectation pending: kind %0d", m_tuser);
                errors++;
            end else begin
                e = exp_q.pop_front();
                check_field("kind", 32'(e.kind), 32'(m_tuser));
                check_field("key_byte", 32'(e.key_byte), 32'(m_tdata[7:0]));
                check_field("key_length", 32'(e.key_length), 32'(m_tdata[13:8]));
                check_field("has_key", 32'(e.has_key), 32'(m_tdata[14]));
                check_field("reply_allowed", 32'(e.reply_allowed), 32'(m_tdata[15]));
                check_field("has_qos", 32'(e.has_qos), 32'(m_tdata[16]));
                check_field("qos_value", 32'(unsigned'(e.qos_value)), 32'(m_tdata[24:17]));
                check_field("dlms_version", 32'(e.dlms_version), 32'(m_tdata[32:25]));
                check_field("conformance", e.conformance, m_tdata[64:33]);
                check_field("max_pdu_size", 32'(e.max_pdu_size), 32'(m_tdata[80:65]));
                check_field("error_code", 32'(e.error_code), 32'(m_tdata[83:81]));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("initiate_request_parser: mismatch");
        $finish;
    end

endmodule

### files.f
hw/rtl/irp_pkg.sv
hw/rtl/irp_in_reg.sv
hw/rtl/irp_decode.sv
hw/rtl/irp_out_reg.sv
hw/rtl/initiate_request_parser.sv
tb/tb_top.sv
